[rtl/pida_pkg.sv]
package pida_pkg;

   localparam int DEPTH = 64;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMDW  = 2;
   localparam int PW    = 8;
   localparam int VW    = 32;
   localparam int STW   = 2;

   localparam logic [CMDW-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMDW-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMDW-1:0] CMD_LIST   = 2'd2;

   localparam logic [STW-1:0] ST_ELEMENT = 2'd0;
   localparam logic [STW-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STW-1:0] ST_DONE    = 2'd2;
   localparam logic [STW-1:0] ST_IGNORED = 2'd3;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_ZERO,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_BELOW,
      RD_ABOVE
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             capture;
      idx_op_type       idx_op;
      logic             mem_rd;
      rd_sel_type       rd_sel;
      logic             mem_wr;
      logic             wr_value;
      logic             cnt_inc;
      logic             cnt_dec;
      logic             out_load;
      logic             out_elem;
      logic [STW-1:0]   out_status;
      logic             out_last;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMDW-1:0]  cmd;
      logic             full;
      logic             del_ok;
      logic             count_zero;
      logic             ins_more;
      logic             del_more;
      logic             list_last;
      logic             out_free;
   } dp_stat_type;

endpackage

[rtl/pida_if.sv]
interface pida_req_if import pida_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMDW-1:0]         cmd;
   logic [PW-1:0]           position;
   logic signed [VW-1:0]    value;

   modport source (output valid, cmd, position, value, input ready);
   modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface pida_rsp_if import pida_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VW-1:0]    element;
   logic [STW-1:0]          status;
   logic                    last;

   modport source (output valid, element, status, last, input ready);
   modport sink   (input valid, element, status, last, output ready);
endinterface

[rtl/pida_ctrl.sv]
module pida_ctrl import pida_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_WR,
      S_LIST_RD,
      S_LIST_OUT,
      S_STATUS
   } state_type;

   state_type      state_ff, state_in;
   logic [STW-1:0] code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      ctl            = '0;
      ctl.idx_op     = IDX_HOLD;
      ctl.rd_sel     = RD_IDX;
      ctl.out_status = ST_DONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_INSERT: begin
                  if (stat.full) begin
                     code_in  = ST_IGNORED;
                     state_in = S_STATUS;
                  end else begin
                     ctl.idx_op = IDX_COUNT;
                     state_in   = S_INS_RD;
                  end
               end
               CMD_DELETE: begin
                  if (!stat.del_ok) begin
                     code_in  = ST_IGNORED;
                     state_in = S_STATUS;
                  end else begin
                     ctl.idx_op = IDX_POS;
                     state_in   = S_DEL_RD;
                  end
               end
               CMD_LIST: begin
                  if (stat.count_zero) begin
                     code_in  = ST_EMPTY;
                     state_in = S_STATUS;
                  end else begin
                     ctl.idx_op = IDX_ZERO;
                     state_in   = S_LIST_RD;
                  end
               end
               default: begin
                  code_in  = ST_IGNORED;
                  state_in = S_STATUS;
               end
            endcase
         end
         S_INS_RD: begin
            if (stat.ins_more) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_BELOW;
               state_in   = S_INS_WR;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_WR: begin
            ctl.mem_wr = 1'b1;
            ctl.idx_op = IDX_DEC;
            state_in   = S_INS_RD;
         end
         S_INS_PUT: begin
            ctl.mem_wr   = 1'b1;
            ctl.wr_value = 1'b1;
            ctl.cnt_inc  = 1'b1;
            code_in      = ST_DONE;
            state_in     = S_STATUS;
         end
         S_DEL_RD: begin
            if (stat.del_more) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_ABOVE;
               state_in   = S_DEL_WR;
            end else begin
               ctl.cnt_dec = 1'b1;
               code_in     = ST_DONE;
               state_in    = S_STATUS;
            end
         end
         S_DEL_WR: begin
            ctl.mem_wr = 1'b1;
            ctl.idx_op = IDX_INC;
            state_in   = S_DEL_RD;
         end
         S_LIST_RD: begin
            ctl.mem_rd = 1'b1;
            ctl.rd_sel = RD_IDX;
            state_in   = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            if (stat.out_free) begin
               ctl.out_load   = 1'b1;
               ctl.out_elem   = 1'b1;
               ctl.out_status = ST_ELEMENT;
               ctl.out_last   = stat.list_last;
               ctl.idx_op     = IDX_INC;
               state_in       = stat.list_last ? S_IDLE : S_LIST_RD;
            end
         end
         S_STATUS: begin
            if (stat.out_free) begin
               ctl.out_load   = 1'b1;
               ctl.out_status = code_ff;
               ctl.out_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

[rtl/pida_dpath.sv]
module pida_dpath import pida_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   pida_req_if.sink        req_ch,
   pida_rsp_if.source      rsp_ch,
   input  ctl_cmd_type     ctl,
   output dp_stat_type     stat
);

   logic [VW-1:0]         mem [DEPTH];
   logic [VW-1:0]         rd_data_ff;
   logic [CMDW-1:0]       cmd_ff;
   logic [PW-1:0]         pos_ff;
   logic [VW-1:0]         val_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]         element_ff;
   logic [STW-1:0]        status_ff;
   logic                  last_ff;

   logic [CW-1:0]         pos_eff;
   logic [CW-1:0]         idx_next;
   logic [AW-1:0]         rd_addr;
   logic [VW-1:0]         wr_data;

   // An insert position past the end appends at the end.
   assign pos_eff  = (pos_ff > PW'(count_ff)) ? count_ff : CW'(pos_ff);
   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      case (ctl.rd_sel)
         RD_BELOW: rd_addr = AW'(idx_ff - CW'(1));
         RD_ABOVE: rd_addr = AW'(idx_next);
         default:  rd_addr = idx_ff[AW-1:0];
      endcase
   end

   assign wr_data = ctl.wr_value ? val_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         mem[idx_ff[AW-1:0]] <= wr_data;
      end
      if (ctl.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= req_ch.cmd;
         pos_ff <= req_ch.position;
         val_ff <= req_ch.value;
      end
      if (ctl.out_load) begin
         element_ff <= ctl.out_elem ? rd_data_ff : '0;
         status_ff  <= ctl.out_status;
         last_ff    <= ctl.out_last;
      end
   end

   always_comb begin
      case (ctl.idx_op)
         IDX_COUNT: idx_in = count_ff;
         IDX_POS:   idx_in = CW'(pos_ff);
         IDX_ZERO:  idx_in = '0;
         IDX_INC:   idx_in = idx_next;
         IDX_DEC:   idx_in = idx_ff - CW'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.cmd        = cmd_ff;
   assign stat.full       = (count_ff == CW'(DEPTH));
   assign stat.del_ok     = (pos_ff < PW'(count_ff));
   assign stat.count_zero = (count_ff == '0);
   assign stat.ins_more   = (idx_ff > pos_eff);
   assign stat.del_more   = (idx_next < count_ff);
   assign stat.list_last  = (idx_next == count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.element = element_ff;
   assign rsp_ch.status  = status_ff;
   assign rsp_ch.last    = last_ff;

endmodule

[rtl/positional_insert_delete_array.sv]
// Ordered list of up to DEPTH signed 32-bit values with insert, delete and listing.
//
// Commands arrive on the req_ch item channel (cmd, position, value) and results
// leave on the rsp_ch item channel (element, status, last); both use valid/ready
// and move an item at an edge where both are high. Insert and delete each give
// one status item. A listing gives one item per held entry, the final one with
// last set, or a single empty-list item when nothing is held.
// The block works on one command at a time: it first decodes the command, then
// entries move through the entry memory one at a time, each by a read and then a
// write. An insert then writes its value into the freed slot and a delete lowers
// the count; each then loads its status item into the output register, as does an
// ignored command or an empty listing straight after decoding. A listing reads
// each entry in turn and loads it once the output register is free. The controller
// is idle, and takes the next command, the cycle after it loads its final item.
// Reset is synchronous and active high; it empties the list and drops any
// pending result. The entry memory needs no clearing, since only entries below
// the count are ever read. Results sit in an output register: a stalled
// receiver holds that item steady, and the block keeps accepting and working on
// the next command until it needs the output register again.
module positional_insert_delete_array import pida_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pida_req_if.sink   req_ch,
   pida_rsp_if.source rsp_ch
);

   ctl_cmd_type ctl;
   dp_stat_type stat;
   logic        ready;

   // The controller sequences the shifts and the listing; the datapath owns the
   // entry memory, the count, the walking index and the output register.
   pida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   pida_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .ctl    (ctl),
      .stat   (stat)
   );

   // A new command is taken only while the controller is idle.
   assign req_ch.ready = ready;

endmodule

[rtl/pida_checker.sv]
module pida_checker import pida_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [VW-1:0] rsp_element,
   input logic [STW-1:0]       rsp_status,
   input logic                 rsp_last
);

   // A stalled result holds steady.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_element) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   // Every status or empty-list result is the only result of its command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_ELEMENT) |-> rsp_last)
      else $error("status result without last");

   // Status results carry a zero element.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_ELEMENT) |-> (rsp_element == '0))
      else $error("status result with nonzero element");

   // Reset drops any pending result.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_element (rsp_ch.element),
   .rsp_status  (rsp_ch.status),
   .rsp_last    (rsp_ch.last)
);

[test/positional_insert_delete_array_tb.sv]
`timescale 1ns / 1ps

module positional_insert_delete_array_tb import pida_pkg::*; ();

   // The package names insert, delete and list. The fourth code is unused by the
   // block and must come back as an ignored item.
   localparam logic [CMDW-1:0] CMD_UNUSED = 2'd3;

   // The receiver's long hold-off, the no-progress limit and the settle time at the end.
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

   typedef struct packed {
      logic signed [VW-1:0] element;
      logic [STW-1:0]       status;
      logic                 last;
   } list_result_type;

   // One row of the directed part. Where typed is set, the expected item is the
   // status given here, with element zero and last set. Otherwise the expected
   // items come from the list model below.
   typedef struct packed {
      logic [CMDW-1:0]      cmd;
      logic [PW-1:0]        position;
      logic signed [VW-1:0] value;
      logic                 typed;
      logic [STW-1:0]       status;
   } directed_row_type;

   logic clock;
   logic reset;

   pida_req_if req_ch ();
   pida_rsp_if rsp_ch ();

   positional_insert_delete_array dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The testbench's own copy of the list. Only the first held_count entries are
   // ever read, so the stale contents above the count never matter.
   logic signed [VW-1:0] held_values [DEPTH];
   logic [CW-1:0]        held_count;

   // Items the block still owes us, oldest first.
   list_result_type  awaited_results [$];
   int               error_count;

   // The sender's idle rate is read only by the main process. The receiver's rate
   // is handed over with a nonblocking write, so its process always sees a settled value.
   int               tx_idle_pct;
   int               rx_idle_pct;
   int               hold_req_seq;
   bit               growing;

   directed_row_type directed_rows [22];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one accepted command to the list copy. Unless push is clear, it also
   // queues every item that the command should produce.
   task automatic predict_list_op(input logic [CMDW-1:0] c, input logic [PW-1:0] p,
                                  input logic signed [VW-1:0] v, input bit push);
      int              slot;
      list_result_type r;
      r.element = '0;
      r.status  = ST_IGNORED;
      r.last    = 1'b1;
      case (c)
         CMD_INSERT: begin
            // A full list takes nothing. A position at or past the end appends.
            if (int'(held_count) < DEPTH) begin
               slot = (int'(p) > int'(held_count)) ? int'(held_count) : int'(p);
               for (int i = int'(held_count); i > slot; i--)
                  held_values[i] = held_values[i - 1];
               held_values[slot] = v;
               held_count++;
               r.status = ST_DONE;
            end
         end
         CMD_DELETE: begin
            // Only a position below the count removes anything.
            if (int'(p) < int'(held_count)) begin
               for (int i = int'(p); i + 1 < int'(held_count); i++)
                  held_values[i] = held_values[i + 1];
               held_count--;
               r.status = ST_DONE;
            end
         end
         CMD_LIST: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else if (push) begin
               for (int i = 0; i < int'(held_count); i++) begin
                  r.element = held_values[i];
                  r.status  = ST_ELEMENT;
                  r.last    = (i + 1 == int'(held_count));
                  awaited_results.push_back(r);
               end
            end
         end
         default: ;
      endcase
      // A listing that is not empty has already queued its items.
      if (push && !(c == CMD_LIST && held_count != 0))
         awaited_results.push_back(r);
   endtask

   // Offers one command and holds it until the block takes it. Random idle cycles
   // come first, so a gap can fall anywhere in the block's work.
   task automatic send_command(input logic [CMDW-1:0] c, input logic [PW-1:0] p,
                               input logic signed [VW-1:0] v, input bit typed,
                               input logic [STW-1:0] typed_status);
      list_result_type r;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= c;
      req_ch.position <= p;
      req_ch.value    <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // The block took the item at this edge. Update the list copy in order.
      predict_list_op(c, p, v, !typed);
      if (typed) begin
         r.element = '0;
         r.status  = typed_status;
         r.last    = 1'b1;
         awaited_results.push_back(r);
      end
   endtask

   // Stops offering and waits until every queued item has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Random commands. The list swings between empty and full, so that inserts
   // into a full list and deletes on an empty one come up again and again. Most
   // positions fall inside the list or just past its end. The rest span the whole
   // field, so that every position bit is driven both ways.
   task automatic run_random(input int n);
      logic [CMDW-1:0]      c;
      logic [PW-1:0]        p;
      logic signed [VW-1:0] v;
      int                   roll;
      for (int k = 0; k < n; k++) begin
         if (int'(held_count) == DEPTH && $urandom_range(3) == 0)
            growing = 1'b0;
         else if (held_count == 0 && $urandom_range(3) == 0)
            growing = 1'b1;

         roll = $urandom_range(99);
         if (roll < 5)
            c = CMD_UNUSED;
         else if (roll < 15)
            c = CMD_LIST;
         else if (roll < 85)
            c = growing ? CMD_INSERT : CMD_DELETE;
         else
            c = growing ? CMD_DELETE : CMD_INSERT;

         if ($urandom_range(99) < 70)
            p = PW'($urandom_range(int'(held_count), 0));
         else
            p = PW'($urandom_range(255));

         roll = $urandom_range(99);
         if (roll < 10) begin
            case ($urandom_range(3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7fff_ffff;
               2:       v = '0;
               default: v = -32'sd1;
            endcase
         end else if (roll < 20) begin
            v = $signed($urandom_range(20)) - 32'sd10;
         end else begin
            v = $urandom;
         end
         send_command(c, p, v, 1'b0, ST_IGNORED);
      end
   endtask

   // Receiver side. This process counts the long hold-off itself, so the main
   // process can keep offering commands while the block backs up.
   initial begin : rsp_ready_gen
      int stall_left;
      int hold_seen;
      stall_left = 0;
      hold_seen  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req_seq != hold_seen) begin
            hold_seen  = hold_req_seq;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Each item the block hands over is checked against the oldest expectation.
   always @(posedge clock) begin : result_check
      list_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected item: element %0d status %0d last %0b",
                   rsp_ch.element, rsp_ch.status, rsp_ch.last);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_ch.element !== want.element) begin
               $error("element: expected %0d, got %0d", want.element, rsp_ch.element);
               error_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   // A run that stops moving items on either side for too long has hung.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("positional_insert_delete_array: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      error_count  = 0;
      held_count   = '0;
      growing      = 1'b1;
      tx_idle_pct  = 22;
      hold_req_seq <= 0;
      rx_idle_pct  <= 48;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_LIST;
      req_ch.position <= '0;
      req_ch.value    <= '0;

      // Directed part. It starts from the empty list and covers the empty listing,
      // deletes out of range, the unused code, appends past the end, inserts and
      // deletes at the front, the middle and the back, and extreme values.
      directed_rows = '{
         '{CMD_LIST,   8'd0,   32'sd0,          1'b1, ST_EMPTY},
         '{CMD_DELETE, 8'd0,   32'sd0,          1'b1, ST_IGNORED},
         '{CMD_DELETE, 8'd255, 32'sd0,          1'b1, ST_IGNORED},
         '{CMD_UNUSED, 8'd255, -32'sd1,         1'b1, ST_IGNORED},
         '{CMD_INSERT, 8'd255, 32'sh7fff_ffff,  1'b1, ST_DONE},
         '{CMD_INSERT, 8'd0,   32'sh8000_0000,  1'b1, ST_DONE},
         '{CMD_INSERT, 8'd1,   32'sd0,          1'b1, ST_DONE},
         '{CMD_INSERT, 8'd2,   -32'sd1,         1'b1, ST_DONE},
         '{CMD_INSERT, 8'd200, 32'sh5555_5555,  1'b1, ST_DONE},
         '{CMD_LIST,   8'd0,   32'sd0,          1'b0, ST_ELEMENT},
         '{CMD_INSERT, 8'd4,   32'shaaaa_aaaa,  1'b1, ST_DONE},
         '{CMD_DELETE, 8'd5,   32'sd0,          1'b1, ST_DONE},
         '{CMD_DELETE, 8'd5,   32'sd0,          1'b1, ST_IGNORED},
         '{CMD_DELETE, 8'd0,   32'sd0,          1'b1, ST_DONE},
         '{CMD_DELETE, 8'd2,   32'sd0,          1'b1, ST_DONE},
         '{CMD_LIST,   8'd170, 32'sd0,          1'b0, ST_ELEMENT},
         '{CMD_DELETE, 8'd1,   32'sd0,          1'b1, ST_DONE},
         '{CMD_DELETE, 8'd1,   32'sd0,          1'b1, ST_DONE},
         '{CMD_LIST,   8'd85,  32'sd0,          1'b0, ST_ELEMENT},
         '{CMD_DELETE, 8'd0,   32'sd0,          1'b1, ST_DONE},
         '{CMD_LIST,   8'd0,   32'sd0,          1'b1, ST_EMPTY},
         '{CMD_UNUSED, 8'd0,   32'sd0,          1'b1, ST_IGNORED}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].position,
                      directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].status);
      drain_results();

      // First the receiver stalls more than the sender idles, then the other
      // way round. The sender pauses until everything has come back between phases.
      run_random(150);
      drain_results();

      tx_idle_pct = 48;
      rx_idle_pct <= 22;
      run_random(150);
      drain_results();

      // No idling on either side. Partway through, the receiver holds off for a
      // long stretch while items keep coming, so that the block backs up and
      // stalls its input.
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      run_random(50);
      hold_req_seq <= hold_req_seq + 1;
      run_random(100);
      drain_results();

      // Anything the block sends after this point is unexpected.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d expected items never arrived", awaited_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("positional_insert_delete_array: match");
      else
         $display("positional_insert_delete_array: mismatch");
      $finish;
   end

endmodule
